@@ hdl/binary_insertion_sorter_top_macros.svh @@
// Assertion macros shared by the binary insertion sorter RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef BINARY_INSERTION_SORTER_TOP_MACROS_SVH
`define BINARY_INSERTION_SORTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BIS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bis_pkg.sv @@
// Package for the binary insertion sorter: field widths, defaults and types.
// No dependencies.
package bis_pkg;

    localparam int KEY_W        = 32;
    localparam int PAY_W        = 16;
    localparam int CAPACITY_DEF = 32;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctrl;

endpackage

@@ hdl/bis_cell.sv @@
// One cell of the sorting row: holds one key/payload pair.
// Depends on bis_pkg.
module bis_cell (
    input  logic                               i_clk,
    input  bis_pkg::t_cell_ctrl                i_ctrl,
    input  logic                               i_occupied,
    input  logic signed [bis_pkg::KEY_W-1:0]   i_new_key,
    input  logic        [bis_pkg::PAY_W-1:0]   i_new_payload,
    input  logic                               i_take_prev,
    input  logic signed [bis_pkg::KEY_W-1:0]   i_prev_key,
    input  logic        [bis_pkg::PAY_W-1:0]   i_prev_payload,
    input  logic signed [bis_pkg::KEY_W-1:0]   i_next_key,
    input  logic        [bis_pkg::PAY_W-1:0]   i_next_payload,
    output logic                               o_take,
    output logic signed [bis_pkg::KEY_W-1:0]   o_key,
    output logic        [bis_pkg::PAY_W-1:0]   o_payload
);
    import bis_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic        [PAY_W-1:0] r_payload;
    logic signed [KEY_W-1:0] n_key;
    logic        [PAY_W-1:0] n_payload;

    // Strictly greater keeps equal keys in arrival order.
    assign o_take = !i_occupied || (r_key > i_new_key);

    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        if (i_ctrl.drain) begin
            n_key     = i_next_key;
            n_payload = i_next_payload;
        end else if (i_ctrl.insert && o_take) begin
            if (i_take_prev) begin
                n_key     = i_prev_key;
                n_payload = i_prev_payload;
            end else begin
                n_key     = i_new_key;
                n_payload = i_new_payload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;

endmodule

@@ hdl/binary_insertion_sorter_top.sv @@
// Binary insertion sorter: a row of CAPACITY compare-and-shift cells.
// Loading: one element per cycle, busy stays low; an element that fits lands in its slot.
// On the final element the sorted set streams out in the next cycle, one result per cycle,
// N results for N stored elements; busy is high while they stream. The receiver cannot stall.
// Reset (synchronous, active low) empties the set and clears the drop flag; cell contents
// are left undefined and are never read before written.
module binary_insertion_sorter_top #(
    parameter int CAPACITY = bis_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [bis_pkg::KEY_W-1:0]   i_sort_key,
    input  logic        [bis_pkg::PAY_W-1:0]   i_payload,
    input  logic                               i_final_element,
    output logic                               o_valid,
    output logic signed [bis_pkg::KEY_W-1:0]   o_out_key,
    output logic        [bis_pkg::PAY_W-1:0]   o_out_payload,
    output logic                               o_end_of_run,
    output logic                               o_overflowed
);
    import bis_pkg::*;
    `include "binary_insertion_sorter_top_macros.svh"

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    t_state               r_state;
    t_state               n_state;
    logic [COUNT_W-1:0]   r_count;
    logic [COUNT_W-1:0]   n_count;
    logic                 r_drop;
    logic                 n_drop;
    logic                 accept;
    logic                 full;
    t_cell_ctrl           ctrl;

    logic                    c_take    [CAPACITY];
    logic signed [KEY_W-1:0] c_key     [CAPACITY];
    logic        [PAY_W-1:0] c_payload [CAPACITY];

    assign accept = start && !busy;
    assign full   = (r_count == COUNT_W'(CAPACITY));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        ctrl.insert = 1'b0;
        ctrl.drain  = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (full) begin
                        n_drop = 1'b1;
                    end else begin
                        ctrl.insert = 1'b1;
                        n_count     = r_count + 1'b1;
                    end
                    if (i_final_element) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // Advance the row toward cell 0, one result per cycle.
                ctrl.drain = 1'b1;
                n_count    = r_count - 1'b1;
                if (r_count == COUNT_W'(1)) begin
                    n_state = ST_LOAD;
                    n_drop  = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                    take_prev;
        logic signed [KEY_W-1:0] prev_key;
        logic        [PAY_W-1:0] prev_payload;
        logic signed [KEY_W-1:0] next_key;
        logic        [PAY_W-1:0] next_payload;

        if (g == 0) begin : g_head
            assign take_prev    = 1'b0;
            assign prev_key     = i_sort_key;
            assign prev_payload = i_payload;
        end else begin : g_body
            assign take_prev    = c_take[g-1];
            assign prev_key     = c_key[g-1];
            assign prev_payload = c_payload[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_key     = c_key[g];
            assign next_payload = c_payload[g];
        end else begin : g_inner
            assign next_key     = c_key[g+1];
            assign next_payload = c_payload[g+1];
        end

        bis_cell u_cell (
            .i_clk          (i_clk),
            .i_ctrl         (ctrl),
            .i_occupied     (COUNT_W'(g) < r_count),
            .i_new_key      (i_sort_key),
            .i_new_payload  (i_payload),
            .i_take_prev    (take_prev),
            .i_prev_key     (prev_key),
            .i_prev_payload (prev_payload),
            .i_next_key     (next_key),
            .i_next_payload (next_payload),
            .o_take         (c_take[g]),
            .o_key          (c_key[g]),
            .o_payload      (c_payload[g])
        );
    end

    assign busy          = (r_state == ST_DRAIN);
    assign o_valid       = (r_state == ST_DRAIN);
    assign o_out_key     = c_key[0];
    assign o_out_payload = c_payload[0];
    assign o_end_of_run  = (r_state == ST_DRAIN) && (r_count == COUNT_W'(1));
    assign o_overflowed  = r_drop;

    `BIS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= COUNT_W'(CAPACITY), "element count exceeds capacity")
    `BIS_ASSERT_NOW(a_drain_nonempty, i_clk, i_rst_n, r_state == ST_DRAIN,
        r_count != '0, "drain with empty set")
    `BIS_ASSERT_NEXT(a_final_emits, i_clk, i_rst_n, accept && i_final_element,
        o_valid, "final element did not start output")
    `BIS_ASSERT_NEXT(a_run_ends, i_clk, i_rst_n, o_valid && o_end_of_run,
        !busy && !o_overflowed && r_count == '0, "run did not return to empty")

endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for binary_insertion_sorter_top: random and directed sets of keyed elements.
// Depends on bis_pkg and the sorter RTL; a built-in insertion predictor checks every result.
module tb_top;

    import bis_pkg::*;

    localparam int SET_CAP     = CAPACITY_DEF;
    localparam int ITEM_TARGET = 460;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 2 * SET_CAP + 8;

    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic        [PAY_W-1:0] pay;
        logic                    fin;
        int unsigned             gap;
        bit                      drain_first;
    } t_elem;

    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic        [PAY_W-1:0] pay;
        logic                    eor;
        logic                    ovf;
    } t_sorted;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic signed [KEY_W-1:0] i_sort_key = '0;
    logic        [PAY_W-1:0] i_payload = '0;
    logic                    i_final_element = 1'b0;
    logic                    busy;
    logic                    o_valid;
    logic signed [KEY_W-1:0] o_out_key;
    logic        [PAY_W-1:0] o_out_payload;
    logic                    o_end_of_run;
    logic                    o_overflowed;

    t_elem   feed_q[$];
    t_sorted sorted_out_q[$];
    t_elem   cur_elem;
    int      items_queued = 0;
    int      items_sent = 0;
    int      idle_left = 0;
    int      fail_cnt = 0;
    int      cycle_cnt = 0;

    // Predictor copy of the sorted set.
    logic signed [KEY_W-1:0] held_keys[SET_CAP];
    logic        [PAY_W-1:0] held_pays[SET_CAP];
    int                      held_count = 0;
    bit                      held_dropped = 1'b0;

    binary_insertion_sorter_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_sort_key      (i_sort_key),
        .i_payload       (i_payload),
        .i_final_element (i_final_element),
        .o_valid         (o_valid),
        .o_out_key       (o_out_key),
        .o_out_payload   (o_out_payload),
        .o_end_of_run    (o_end_of_run),
        .o_overflowed    (o_overflowed)
    );

    always #2 i_clk = ~i_clk;

    // Insert one element after all equal keys or flag a drop; on the final one, emit the whole set.
    function automatic void sort_insert(t_elem e);
        int      lo;
        int      hi;
        int      mid;
        t_sorted r;
        if (held_count < SET_CAP) begin
            lo = 0;
            hi = held_count;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (held_keys[mid] <= e.key) lo = mid + 1;
                else hi = mid;
            end
            for (int i = held_count; i > lo; i--) begin
                held_keys[i] = held_keys[i-1];
                held_pays[i] = held_pays[i-1];
            end
            held_keys[lo] = e.key;
            held_pays[lo] = e.pay;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (e.fin) begin
            for (int i = 0; i < held_count; i++) begin
                r.key = held_keys[i];
                r.pay = held_pays[i];
                r.eor = (i == held_count - 1);
                r.ovf = held_dropped;
                sorted_out_q.push_back(r);
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endfunction

    function automatic logic signed [KEY_W-1:0] draw_key(int mode);
        int k;
        case (mode)
            1: begin
                k = $urandom_range(0, 6);
                return k - 3;
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic push_elem(logic signed [KEY_W-1:0] key, logic [PAY_W-1:0] pay,
                             logic fin, int unsigned gap, bit drain_first);
        t_elem e;
        e.key         = key;
        e.pay         = pay;
        e.fin         = fin;
        e.gap         = gap;
        e.drain_first = drain_first;
        feed_q.push_back(e);
        items_queued++;
    endtask

    task automatic add_set(int len, bit drain_first);
        bit burst;
        int mode;
        burst = ($urandom_range(0, 3) == 0);
        mode  = $urandom_range(0, 2);
        for (int i = 0; i < len; i++) begin
            push_elem(draw_key(mode), PAY_W'($urandom), (i == len - 1),
                      burst ? 0 : $urandom_range(0, 14), (i == 0) && drain_first);
        end
    endtask

    // Driver: present queued elements, hold while busy, idle between them.
    always @(posedge i_clk) begin : driver
        bit took;
        took = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (took) begin
                sort_insert(cur_elem);
                items_sent++;
                idle_left = cur_elem.gap;
            end
            if (!(start && !took)) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (feed_q.size() > 0 &&
                             !(feed_q[0].drain_first && sorted_out_q.size() > 0)) begin
                    cur_elem = feed_q.pop_front();
                    i_sort_key      <= cur_elem.key;
                    i_payload       <= cur_elem.pay;
                    i_final_element <= cur_elem.fin;
                    start           <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expected one.
    always @(posedge i_clk) begin : monitor
        t_sorted want;
        if (i_rst_n && o_valid) begin
            if (sorted_out_q.size() == 0) begin
                $error("unexpected result: key %0d payload %0d", o_out_key, o_out_payload);
                fail_cnt++;
            end else begin
                want = sorted_out_q.pop_front();
                if (o_out_key !== want.key) begin
                    $error("out_key expected %0d got %0d", want.key, o_out_key);
                    fail_cnt++;
                end
                if (o_out_payload !== want.pay) begin
                    $error("out_payload expected %0d got %0d", want.pay, o_out_payload);
                    fail_cnt++;
                end
                if (o_end_of_run !== want.eor) begin
                    $error("end_of_run expected %0d got %0d", want.eor, o_end_of_run);
                    fail_cnt++;
                end
                if (o_overflowed !== want.ovf) begin
                    $error("overflowed expected %0d got %0d", want.ovf, o_overflowed);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        // Single element, most negative key.
        push_elem(32'sh8000_0000, 16'h0000, 1'b1, 0, 1'b0);
        // Extremes, sign boundary and duplicate keys interleaved.
        push_elem(32'sh7FFF_FFFF, 16'hFFFF, 1'b0, 0, 1'b1);
        push_elem(0,              16'h0001, 1'b0, 0, 1'b0);
        push_elem(-1,             16'h0002, 1'b0, 0, 1'b0);
        push_elem(32'sh7FFF_FFFF, 16'h0003, 1'b0, 0, 1'b0);
        push_elem(32'sh8000_0000, 16'h0004, 1'b0, 0, 1'b0);
        push_elem(1,              16'h0005, 1'b0, 0, 1'b0);
        push_elem(0,              16'h0006, 1'b0, 0, 1'b0);
        push_elem(-1,             16'h0007, 1'b1, 0, 1'b0);
        // All keys equal: arrival order must hold.
        for (int i = 0; i < 4; i++) push_elem(32'sh0007_0000, PAY_W'(16'h0010 + i),
                                              (i == 3), 0, 1'b0);
        // Strictly descending keys.
        for (int i = 0; i < 5; i++) push_elem(32'sh0005_8000 - i * 32'sh0001_0000,
                                              PAY_W'(16'h0020 + i), (i == 4), 1, 1'b0);
        push_elem(32'sh7FFF_FFFF, 16'hA5A5, 1'b1, 0, 1'b0);

        // Exactly full, one over, and well over so the final element is dropped.
        add_set(SET_CAP, 1'b1);
        add_set(SET_CAP + 1, 1'b0);
        add_set(SET_CAP + 8, 1'b1);
        while (items_queued < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) add_set($urandom_range(SET_CAP - 4, SET_CAP + 6),
                                                   ($urandom_range(0, 7) == 0));
            else add_set($urandom_range(1, 10), ($urandom_range(0, 7) == 0));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_sent < items_queued) @(posedge i_clk);
        while (sorted_out_q.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && sorted_out_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
